@@ rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value store.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int CAP_W  = 4;
    localparam int LIVE_W = 4;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Operation codes (code 3 is undefined and does nothing)
    typedef enum logic [OP_W-1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2
    } op_t;

    // Flags from the table to the result register
    typedef struct packed {
        logic hit;
        logic evicted;
    } lkv_status_t;

endpackage

@@ rtl/lkv_table.sv @@
// ----------------------------------------------------------------------------
// lkv_table
// Fully associative entry table: parallel key match, LRU victim select,
// free slot select and rank update, all for one operation per cycle while exec is high.
// ----------------------------------------------------------------------------
module lkv_table #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       exec,
    input  logic [lkv_pkg::OP_W-1:0]   opcode,
    input  logic [KEY_BITS-1:0]        key,
    input  logic [VALUE_BITS-1:0]      write_value,
    input  logic [lkv_pkg::CAP_W-1:0]  cap,
    output lkv_pkg::lkv_status_t       status,
    output logic [VALUE_BITS-1:0]      read_value,
    output logic [KEY_BITS-1:0]        evicted_key,
    output logic [lkv_pkg::LIVE_W-1:0] live_count
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Entry state
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [RANK_W-1:0]     rank_reg   [ENTRIES];
    logic [RANK_W-1:0]     rank_next  [ENTRIES];
    logic [KEY_BITS-1:0]   ekey_reg   [ENTRIES];
    logic [KEY_BITS-1:0]   ekey_next  [ENTRIES];
    logic [VALUE_BITS-1:0] evalue_reg [ENTRIES];
    logic [VALUE_BITS-1:0] evalue_next[ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // Lookup terms
    op_t                   op;
    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    victim_oh;
    logic [ENTRIES-1:0]    free_vec;
    logic [ENTRIES-1:0]    free_oh;
    logic [ENTRIES-1:0]    ins_oh;
    logic [RANK_W-1:0]     hit_rank;
    logic [RANK_W-1:0]     lru_rank;
    logic [VALUE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]   victim_key;
    logic [CAP_W-1:0]      cap_lo;
    logic                  found;
    logic                  full;
    logic                  do_evict;

    assign op = op_t'(opcode);

    // Capacity check: count against max(cap,1), saturated at ENTRIES
    assign cap_lo   = (cap == '0) ? CAP_W'(1) : cap;
    assign full     = (count_reg == CNT_W'(ENTRIES))
                   || (CMP_W'(count_reg) >= CMP_W'(cap_lo));
    assign lru_rank = RANK_W'(count_reg - CNT_W'(1));

    // Lowest free slot
    assign free_vec = ~valid_reg;
    assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));

    // Parallel compare and one-hot reads
    always_comb
    begin
        match      = '0;
        victim_oh  = '0;
        hit_rank   = '0;
        hit_value  = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (ekey_reg[i] == key);
            victim_oh[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            hit_rank     = hit_rank   | (match[i]     ? rank_reg[i]   : '0);
            hit_value    = hit_value  | (match[i]     ? evalue_reg[i] : '0);
            victim_key   = victim_key | (victim_oh[i] ? ekey_reg[i]   : '0);
        end
    end

    assign found    = |match;
    assign do_evict = (op == OP_SET) && !found && full;
    assign ins_oh   = full ? victim_oh : free_oh;

    // Next state of every entry
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i]   = rank_reg[i];
            ekey_next[i]   = ekey_reg[i];
            evalue_next[i] = evalue_reg[i];
        end
        case (op)
            OP_SET:
            begin
                if (found)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (match[i])
                        begin
                            evalue_next[i] = write_value;
                            rank_next[i]   = '0;
                        end
                        else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                else
                begin
                    // New entry goes in as most recent; the rest age by one
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (ins_oh[i])
                        begin
                            valid_next[i]  = 1'b1;
                            ekey_next[i]   = key;
                            evalue_next[i] = write_value;
                            rank_next[i]   = '0;
                        end
                        else if (valid_reg[i])
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                    if (!full)
                        count_next = count_reg + CNT_W'(1);
                end
            end
            OP_GET:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match[i])
                        rank_next[i] = '0;
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            OP_DEL:
            begin
                // Only a hit frees a slot and closes the rank gap behind it
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match[i])
                    begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                    else if (found && valid_reg[i] && (rank_reg[i] > hit_rank))
                        rank_next[i] = rank_reg[i] - RANK_W'(1);
                end
                if (found)
                    count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Result terms
    assign status.hit     = found && ((op == OP_SET) || (op == OP_GET) || (op == OP_DEL));
    assign status.evicted = do_evict;
    assign read_value     = ((op == OP_GET) && found) ? hit_value : '0;
    assign evicted_key    = do_evict ? victim_key : '0;
    assign live_count     = LIVE_W'(count_next);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else if (exec)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // Key and value storage
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                ekey_reg[i]   <= ekey_next[i];
                evalue_reg[i] <= evalue_next[i];
            end
        end
    end

    // Checks
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("live count out of step with valid bits");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && do_evict) |-> $onehot(victim_oh))
        else $error("eviction without a unique least recent entry");

    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op == OP_SET) && !found) |-> $onehot(ins_oh))
        else $error("set miss without a slot to fill");

endmodule

@@ rtl/lru_key_value_store.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_store
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, key and write_value:
//   set, get or delete. Output channel (out_valid / out_stall) returns one
//   result per operation: hit, read_value, evicted, evicted_key, live_count.
//   A transfer happens on a rising edge with valid high and stall low. The
//   config channel (cfg_valid / cfg_ready) writes capacity_limit and is
//   always ready; write it only while the store is idle; nothing enforces it.
// Timing:
//   An accepted operation is held in the input register and is executed once
//   the output register is free or draining; that execution writes its
//   result into the output register. One operation per cycle is sustained
//   while out_stall stays low; the table lookup and rank update are one
//   combinational pass between the two registers.
// Reset:
//   All entries become invalid, the capacity register returns to 8, no
//   result is pending. When out_stall holds a result, the operation behind
//   it waits in the input register and in_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module lru_key_value_store #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // operation channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lkv_pkg::OP_W-1:0]   opcode,
    input  logic [KEY_BITS-1:0]        key,
    input  logic [VALUE_BITS-1:0]      write_value,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [VALUE_BITS-1:0]      read_value,
    output logic                       evicted,
    output logic [KEY_BITS-1:0]        evicted_key,
    output logic [lkv_pkg::LIVE_W-1:0] live_count,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]  capacity_limit
);
    import lkv_pkg::*;

    logic                  in_vld_reg;
    logic [OP_W-1:0]       in_op_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_wval_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic                  out_hit_reg;
    logic                  out_ev_reg;
    logic [VALUE_BITS-1:0] out_rval_reg;
    logic [KEY_BITS-1:0]   out_evkey_reg;
    logic [LIVE_W-1:0]     out_live_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic                  advance;
    logic                  in_take;
    lkv_status_t           tbl_status;
    logic [VALUE_BITS-1:0] tbl_rval;
    logic [KEY_BITS-1:0]   tbl_evkey;
    logic [LIVE_W-1:0]     tbl_live;

    // Handshake: execute when the output register is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_vld_next = advance ? 1'b1 : (out_vld_reg && out_stall);

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= capacity_limit;
    end

    // Valid flags of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_take || in_stall;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= opcode;
            in_key_reg  <= key;
            in_wval_reg <= write_value;
        end
    end

    // Entry table
    lkv_table #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .exec        (advance),
        .opcode      (in_op_reg),
        .key         (in_key_reg),
        .write_value (in_wval_reg),
        .cap         (cap_reg),
        .status      (tbl_status),
        .read_value  (tbl_rval),
        .evicted_key (tbl_evkey),
        .live_count  (tbl_live)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hit_reg   <= tbl_status.hit;
            out_ev_reg    <= tbl_status.evicted;
            out_rval_reg  <= tbl_rval;
            out_evkey_reg <= tbl_evkey;
            out_live_reg  <= tbl_live;
        end
    end

    assign out_valid   = out_vld_reg;
    assign hit         = out_hit_reg;
    assign evicted     = out_ev_reg;
    assign read_value  = out_rval_reg;
    assign evicted_key = out_evkey_reg;
    assign live_count  = out_live_reg;

endmodule
